@@ rtl/core/assert_macros.svh @@
// assertion macros used by the rtl of the matrix multiply block
// expects a clock named clk and an active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/sqmm_pkg.sv @@
// shared constants, sequencer states and helpers for the square matrix multiply
// no dependencies
`timescale 1ns / 1ps

package sqmm_pkg;

  localparam int MAX_SIZE     = 8;
  localparam int ELEMENT_BITS = 16;

  localparam int STORE_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
  localparam int COUNT_BITS  = $clog2(STORE_DEPTH + 1);
  localparam int IDX_BITS    = $clog2(MAX_SIZE);
  localparam int PROD_BITS   = 2 * ELEMENT_BITS;

  // fixed field widths of the ports
  localparam int SIZE_BITS      = 4;
  localparam int VALUE_BITS     = 35;
  localparam int ROW_BITS       = 3;
  localparam int IN_TDATA_BITS  = 2 * ELEMENT_BITS;
  localparam int OUT_BITS       = VALUE_BITS + 2 * ROW_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_OUT
  } state_t;

  // size register to the size in use: zero acts as one, large values saturate
  function automatic logic [SIZE_BITS-1:0] effective_size(input logic [SIZE_BITS-1:0] raw);
    logic [SIZE_BITS-1:0] n;
    n = raw;
    if (raw == '0) begin
      n = SIZE_BITS'(1);
    end else if (raw > SIZE_BITS'(MAX_SIZE)) begin
      n = SIZE_BITS'(MAX_SIZE);
    end
    return n;
  endfunction

endpackage

@@ rtl/core/square_matrix_multiply.sv @@
// square matrix multiply C = A * B on signed Q8.8 elements, one shared MAC
// depends on sqmm_pkg and assert_macros.svh
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    s_tdata: a_element, b_element
// m_*      out  m_tvalid/m_tready    m_tdata: result_value, result_row, result_column; m_tlast
// cfg_*    in   cfg_valid/cfg_ready  cfg_data: matrix_size
//
// loading takes one word a cycle while no size write is offered; the n*n-th word
// starts the product pass; each product element uses the single multiply-accumulate
// (one read of each store per cycle, registered read, product, add), then waits in
// the output register until taken; input stays stalled until the last element leaves
// size writes are taken only while loading, win over a load word in the same cycle
// and clear the load count; the stores need no clearing after reset
`timescale 1ns / 1ps

`include "assert_macros.svh"

module square_matrix_multiply (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [sqmm_pkg::IN_TDATA_BITS-1:0]    s_tdata,   // a_element, b_element
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata: result_value, result_row, result_column, zero pad
  output logic [sqmm_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sqmm_pkg::SIZE_BITS-1:0]        cfg_data
);

  localparam int EB = sqmm_pkg::ELEMENT_BITS;
  localparam int AB = sqmm_pkg::ADDR_BITS;
  localparam int PAD_BITS = sqmm_pkg::OUT_TDATA_BITS - sqmm_pkg::OUT_BITS;

  sqmm_pkg::state_t state, state_next;

  logic [sqmm_pkg::SIZE_BITS-1:0]  matrix_size;
  logic [sqmm_pkg::SIZE_BITS-1:0]  n;
  logic [sqmm_pkg::COUNT_BITS-1:0] total;
  logic [sqmm_pkg::COUNT_BITS-1:0] loaded_count;

  logic [EB-1:0] a_mem [sqmm_pkg::STORE_DEPTH];
  logic [EB-1:0] b_mem [sqmm_pkg::STORE_DEPTH];

  // sequencer counters
  logic [sqmm_pkg::IDX_BITS-1:0] row, col, k;
  logic [AB-1:0] row_base, a_addr, b_addr;
  logic          issue_done;

  // mac pipeline
  logic                                issue;
  logic                                rd_valid, rd_last;
  logic signed [EB-1:0]                a_rd, b_rd;
  logic                                prod_valid, prod_last;
  logic signed [sqmm_pkg::PROD_BITS-1:0]  prod;
  logic signed [sqmm_pkg::VALUE_BITS-1:0] acc, acc_sum;

  logic [sqmm_pkg::VALUE_BITS-1:0] out_value;
  logic [sqmm_pkg::IDX_BITS-1:0]   out_row, out_col;
  logic                            out_last;

  logic in_fire, out_fire, load_done, calc_done;
  logic k_last, col_last, row_last;

  assign n     = sqmm_pkg::effective_size(matrix_size);
  assign total = sqmm_pkg::COUNT_BITS'(n) * sqmm_pkg::COUNT_BITS'(n);

  assign in_fire   = s_tvalid && s_tready;
  assign out_fire  = m_tvalid && m_tready;
  assign load_done = in_fire && (loaded_count + 1'b1 == total);
  assign calc_done = prod_valid && prod_last;

  assign k_last   = (sqmm_pkg::SIZE_BITS'(k)   == n - 1'b1);
  assign col_last = (sqmm_pkg::SIZE_BITS'(col) == n - 1'b1);
  assign row_last = (sqmm_pkg::SIZE_BITS'(row) == n - 1'b1);

  assign issue   = (state == sqmm_pkg::ST_CALC) && !issue_done;
  assign acc_sum = acc + sqmm_pkg::VALUE_BITS'(prod);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sqmm_pkg::ST_LOAD: if (load_done) state_next = sqmm_pkg::ST_CALC;
      sqmm_pkg::ST_CALC: if (calc_done) state_next = sqmm_pkg::ST_OUT;
      sqmm_pkg::ST_OUT: begin
        if (out_fire) begin
          state_next = out_last ? sqmm_pkg::ST_LOAD : sqmm_pkg::ST_CALC;
        end
      end
      default: state_next = sqmm_pkg::ST_LOAD;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_tready  = 1'b0;
    m_tvalid  = 1'b0;
    cfg_ready = 1'b0;
    case (state)
      sqmm_pkg::ST_LOAD: begin
        // a size write goes first, the load word waits until no size write is offered
        s_tready  = !cfg_valid;
        cfg_ready = 1'b1;
      end
      sqmm_pkg::ST_OUT:  m_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_tdata   = {{PAD_BITS{1'b0}}, sqmm_pkg::ROW_BITS'(out_col),
                      sqmm_pkg::ROW_BITS'(out_row), out_value};
  assign m_tlast   = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sqmm_pkg::ST_LOAD;
      matrix_size  <= sqmm_pkg::SIZE_BITS'(sqmm_pkg::MAX_SIZE);
      loaded_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        matrix_size  <= cfg_data;
        loaded_count <= '0;
      end else if (load_done) begin
        loaded_count <= '0;
      end else if (in_fire) begin
        loaded_count <= loaded_count + 1'b1;
      end
    end
  end

  // element stores: one write port for loading, one registered read port for the mac
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_mem[loaded_count[AB-1:0]] <= s_tdata[EB-1:0];
    end
    if (issue) begin
      a_rd <= a_mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_mem[loaded_count[AB-1:0]] <= s_tdata[2*EB-1:EB];
    end
    if (issue) begin
      b_rd <= b_mem[b_addr];
    end
  end

  // address sequencer: a walks along a row, b walks down a column
  always_ff @(posedge clk) begin
    if (rst) begin
      row        <= '0;
      col        <= '0;
      k          <= '0;
      row_base   <= '0;
      a_addr     <= '0;
      b_addr     <= '0;
      issue_done <= 1'b1;
    end else if (load_done) begin
      row        <= '0;
      col        <= '0;
      k          <= '0;
      row_base   <= '0;
      a_addr     <= '0;
      b_addr     <= '0;
      issue_done <= 1'b0;
    end else if (out_fire && !out_last) begin
      k          <= '0;
      issue_done <= 1'b0;
      if (col_last) begin
        col      <= '0;
        row      <= row + 1'b1;
        row_base <= row_base + AB'(n);
        a_addr   <= row_base + AB'(n);
        b_addr   <= '0;
      end else begin
        col    <= col + 1'b1;
        a_addr <= row_base;
        b_addr <= AB'(col) + 1'b1;
      end
    end else if (issue) begin
      k      <= k + 1'b1;
      a_addr <= a_addr + 1'b1;
      b_addr <= b_addr + AB'(n);
      if (k_last) begin
        issue_done <= 1'b1;
      end
    end
  end

  // multiply then accumulate, one product per cycle while the sequencer issues
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      rd_last    <= 1'b0;
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      acc        <= '0;
    end else begin
      rd_valid   <= issue;
      rd_last    <= issue && k_last;
      prod_valid <= rd_valid;
      prod_last  <= rd_last;
      if (prod_valid) begin
        acc <= prod_last ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prod <= a_rd * b_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_last <= 1'b0;
    end else if (calc_done) begin
      out_last <= row_last && col_last;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_done) begin
      out_value <= acc_sum;
      out_row   <= row;
      out_col   <= col;
    end
  end

  `ASSERT_ALWAYS(a_count_in_range, loaded_count < total, "load count reached matrix size")
  `ASSERT_IMPLY(a_idle_pipe, s_tready, !rd_valid && !prod_valid && acc == '0,
                "mac pipeline busy while loading")
  `ASSERT_IMPLY(a_out_pipe_empty, m_tvalid, !rd_valid && !prod_valid && issue_done,
                "mac still running while result shown")
  `ASSERT_NEXT(a_last_reloads, out_fire && m_tlast,
               state == sqmm_pkg::ST_LOAD && loaded_count == '0,
               "block not reloading after final element")

endmodule
